### design/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, held off while reset is low.
`define ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rosa_pkg.sv
package rosa_pkg;

  localparam int OBJECT_SLOTS_DEF = 64;
  localparam int FIELD_SLOTS_DEF  = 256;

  // bitmap word: slots checked per search step
  localparam int WORD_BITS = 8;
  localparam int WORD_LOG  = 3;

  localparam int CNT_W = 16;
  localparam int CLS_W = 16;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RETAIN  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_POOL_FULL  = 2'd2,
    ST_IGNORED    = 2'd3
  } status_t;

endpackage

### design/refcounted_object_slot_allocator_unit.sv
// Reference-counted object slot allocator. One request beat in, one result
// beat out. Allocate scans the slot table for the lowest slot with a zero
// count (one RAM read per slot), then scans the field bitmap first fit, one
// 8-slot word at a time, then marks the run word by word with a read and a
// write per word touched. Retain/release reads the slot and writes back the
// new count; a release to zero also clears the run's words. After reset a
// clearing pass over max(OBJECT_SLOTS, ceil(FIELD_SLOTS/8)) addresses zeroes
// both RAMs; no request is taken until it ends. The result sits in an output
// register, so the next request is taken while the last result still waits
// on out_tready.
`include "assert_macros.svh"

module refcounted_object_slot_allocator_unit
  import rosa_pkg::*;
#(
  parameter int OBJECT_SLOTS = OBJECT_SLOTS_DEF,
  parameter int FIELD_SLOTS  = FIELD_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] class_number, [24:16] fields_wanted, [30:25] object_index
  input  logic [31:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] slot_index, [6] freed, [14:7] run_start, [23:15] run_length,
  // [39:24] class_out, [55:40] count_after
  output logic [55:0] out_tdata,
  // [1:0] status
  output logic [1:0]  out_tuser
);

  localparam int SAW   = $clog2(OBJECT_SLOTS);
  localparam int WORDS = (FIELD_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int GW    = WAW + WORD_LOG;
  localparam int LW    = ($clog2(FIELD_SLOTS + 1) > 9) ? $clog2(FIELD_SLOTS + 1) : 9;
  localparam int MAXD  = (OBJECT_SLOTS > WORDS) ? OBJECT_SLOTS : WORDS;
  localparam int CLW   = $clog2(MAXD);
  localparam int EW    = CNT_W + CLS_W + GW + LW;

  typedef enum logic [10:0] {
    S_CLR  = 11'b00000000001,
    S_IDLE = 11'b00000000010,
    S_SRD  = 11'b00000000100,
    S_SCHK = 11'b00000001000,
    S_FRD  = 11'b00000010000,
    S_FCHK = 11'b00000100000,
    S_MRD  = 11'b00001000000,
    S_MWR  = 11'b00010000000,
    S_ORD  = 11'b00100000000,
    S_OCHK = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

  typedef struct packed {
    status_t          st;
    logic [SAW-1:0]   slot;
    logic             freed;
    logic [GW-1:0]    start;
    logic [LW-1:0]    len;
    logic [CLS_W-1:0] cls;
    logic [CNT_W-1:0] cnt;
  } res_t;

  state_t state_r, state_nxt;
  logic [CLW-1:0] clr_r, clr_nxt;
  op_t op_r, op_nxt;
  logic [CLS_W-1:0] cls_r, cls_nxt;
  logic [8:0] n_r, n_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic [SAW-1:0] sidx_r, sidx_nxt;
  logic [WAW-1:0] wptr_r, wptr_nxt;
  logic [LW-1:0] run_r, run_nxt;
  logic [GW-1:0] start_r, start_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic set_r, set_nxt;
  res_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  res_t out_r, out_nxt;

  // slot table RAM: {count, class, run start, run length}
  logic sl_we;
  logic [SAW-1:0] sl_waddr, sl_raddr;
  logic [EW-1:0] sl_wdata, sl_rdata;
  logic [CNT_W-1:0] rd_cnt;
  logic [CLS_W-1:0] rd_cls;
  logic [GW-1:0] rd_rs;
  logic [LW-1:0] rd_rl;

  // field bitmap RAM
  logic fd_we;
  logic [WAW-1:0] fd_waddr, fd_raddr;
  logic [WORD_BITS-1:0] fd_wdata, fd_rdata;

  rosa_ram #(.WIDTH(EW), .DEPTH(OBJECT_SLOTS)) u_slot_ram (
    .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .raddr(sl_raddr), .rdata(sl_rdata)
  );

  rosa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_field_ram (
    .clk(clk), .we(fd_we), .waddr(fd_waddr), .wdata(fd_wdata),
    .raddr(fd_raddr), .rdata(fd_rdata)
  );

  assign {rd_cnt, rd_cls, rd_rs, rd_rl} = sl_rdata;

  // first-fit scan of one bitmap word, continuing the run from earlier words
  logic [LW-1:0] run_v;
  logic hit_v;
  logic [GW-1:0] hit_start;
  logic [GW-1:0] g_v;
  always_comb begin
    run_v = run_r;
    hit_v = 1'b0;
    hit_start = '0;
    g_v = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      g_v = {wptr_r, WORD_LOG'(i)};
      if (!hit_v) begin
        if (fd_rdata[i] || (32'(g_v) >= FIELD_SLOTS)) begin
          run_v = '0;
        end else begin
          run_v = run_v + LW'(1);
          if (run_v == LW'(n_r)) begin
            hit_v = 1'b1;
            hit_start = GW'(32'(g_v) + 32'd1 - 32'(n_r));
          end
        end
      end
    end
  end

  // range mask for marking or freeing the current word
  logic [WORD_BITS-1:0] run_mask;
  logic [GW:0] run_end;
  logic last_word;
  always_comb begin
    run_end = (GW + 1)'(start_r) + (GW + 1)'(len_r);
    for (int i = 0; i < WORD_BITS; i++) begin
      run_mask[i] = ({1'b0, wptr_r, WORD_LOG'(i)} >= {1'b0, start_r}) &&
                    ({1'b0, wptr_r, WORD_LOG'(i)} < run_end);
    end
    last_word = ({1'b0, wptr_r, {WORD_LOG{1'b1}}} + (GW + 1)'(1)) >= run_end;
  end

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    op_nxt = op_r;
    cls_nxt = cls_r;
    n_nxt = n_r;
    idx_nxt = idx_r;
    sidx_nxt = sidx_r;
    wptr_nxt = wptr_r;
    run_nxt = run_r;
    start_nxt = start_r;
    len_nxt = len_r;
    set_nxt = set_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    sl_we = 1'b0;
    sl_waddr = sidx_r;
    sl_wdata = '0;
    sl_raddr = sidx_r;
    fd_we = 1'b0;
    fd_waddr = wptr_r;
    fd_wdata = '0;
    fd_raddr = wptr_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        sl_we = (32'(clr_r) < OBJECT_SLOTS);
        sl_waddr = SAW'(clr_r);
        fd_we = (32'(clr_r) < WORDS);
        fd_waddr = WAW'(clr_r);
        clr_nxt = clr_r + CLW'(1);
        if (32'(clr_r) == MAXD - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt = op_t'(in_tuser);
          cls_nxt = in_tdata[15:0];
          n_nxt = in_tdata[24:16];
          idx_nxt = in_tdata[30:25];
          sidx_nxt = '0;
          res_nxt = '0;
          if (op_t'(in_tuser) == OP_ALLOC) begin
            state_nxt = S_SRD;
          end else if (32'(in_tdata[30:25]) >= OBJECT_SLOTS) begin
            res_nxt.st = ST_IGNORED;
            res_nxt.slot = SAW'(in_tdata[30:25]);
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_ORD;
          end
        end
      end
      S_SRD: begin
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (rd_cnt == '0) begin
          if (n_r == '0) begin
            sl_we = 1'b1;
            sl_wdata = {CNT_W'(1), cls_r, GW'(0), LW'(0)};
            res_nxt = '{st: ST_OK, slot: sidx_r, freed: 1'b0, start: '0, len: '0,
                        cls: cls_r, cnt: CNT_W'(1)};
            state_nxt = S_DONE;
          end else if (32'(n_r) > FIELD_SLOTS) begin
            res_nxt.st = ST_POOL_FULL;
            state_nxt = S_DONE;
          end else begin
            wptr_nxt = '0;
            run_nxt = '0;
            state_nxt = S_FRD;
          end
        end else if (32'(sidx_r) == OBJECT_SLOTS - 1) begin
          res_nxt.st = ST_TABLE_FULL;
          state_nxt = S_DONE;
        end else begin
          sidx_nxt = sidx_r + SAW'(1);
          state_nxt = S_SRD;
        end
      end
      S_FRD: begin
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (hit_v) begin
          start_nxt = hit_start;
          len_nxt = LW'(n_r);
          set_nxt = 1'b1;
          wptr_nxt = hit_start[GW-1:WORD_LOG];
          state_nxt = S_MRD;
        end else if (32'(wptr_r) == WORDS - 1) begin
          res_nxt.st = ST_POOL_FULL;
          state_nxt = S_DONE;
        end else begin
          run_nxt = run_v;
          wptr_nxt = wptr_r + WAW'(1);
          state_nxt = S_FRD;
        end
      end
      S_MRD: begin
        state_nxt = S_MWR;
      end
      S_MWR: begin
        fd_we = 1'b1;
        fd_wdata = set_r ? (fd_rdata | run_mask) : (fd_rdata & ~run_mask);
        if (last_word) begin
          if (set_r) begin
            sl_we = 1'b1;
            sl_wdata = {CNT_W'(1), cls_r, start_r, len_r};
            res_nxt = '{st: ST_OK, slot: sidx_r, freed: 1'b0, start: start_r,
                        len: len_r, cls: cls_r, cnt: CNT_W'(1)};
          end
          state_nxt = S_DONE;
        end else begin
          wptr_nxt = wptr_r + WAW'(1);
          state_nxt = S_MRD;
        end
      end
      S_ORD: begin
        sl_raddr = SAW'(idx_r);
        state_nxt = S_OCHK;
      end
      S_OCHK: begin
        sl_waddr = SAW'(idx_r);
        res_nxt = '{st: ST_OK, slot: SAW'(idx_r), freed: 1'b0, start: rd_rs,
                    len: rd_rl, cls: rd_cls, cnt: rd_cnt};
        state_nxt = S_DONE;
        unique case (op_r)
          OP_RETAIN: begin
            sl_we = 1'b1;
            if (rd_cnt != '1) begin
              res_nxt.cnt = rd_cnt + CNT_W'(1);
            end
            sl_wdata = {res_nxt.cnt, rd_cls, rd_rs, rd_rl};
          end
          OP_RELEASE: begin
            if (rd_cnt == '0) begin
              res_nxt.st = ST_IGNORED;
              res_nxt.start = '0;
              res_nxt.len = '0;
            end else if (rd_cnt == CNT_W'(1)) begin
              // last reference: clear the slot, then hand the run back
              sl_we = 1'b1;
              sl_wdata = '0;
              res_nxt.freed = 1'b1;
              res_nxt.cnt = '0;
              start_nxt = rd_rs;
              len_nxt = rd_rl;
              set_nxt = 1'b0;
              wptr_nxt = rd_rs[GW-1:WORD_LOG];
              if (rd_rl != '0) begin
                state_nxt = S_MRD;
              end
            end else begin
              sl_we = 1'b1;
              res_nxt.cnt = rd_cnt - CNT_W'(1);
              sl_wdata = {res_nxt.cnt, rd_cls, rd_rs, rd_rl};
            end
          end
          default: begin
            // operation code 3 and stray allocate: plain read
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r <= op_nxt;
    cls_r <= cls_nxt;
    n_r <= n_nxt;
    idx_r <= idx_nxt;
    sidx_r <= sidx_nxt;
    wptr_r <= wptr_nxt;
    run_r <= run_nxt;
    start_r <= start_nxt;
    len_r <= len_nxt;
    set_r <= set_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  logic [31:0] slot_w, start_w, len_w;
  assign slot_w = 32'(out_r.slot);
  assign start_w = 32'(out_r.start);
  assign len_w = 32'(out_r.len);

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_r.st;
  assign out_tdata = {out_r.cnt, out_r.cls, len_w[8:0], start_w[7:0], out_r.freed,
                      slot_w[5:0]};

  // a found run must lie inside the pool
  `ASSERT_IMP(a_run_in_pool, clk, rst_n, (state_r == S_FCHK) && hit_v,
    (32'(hit_start) + 32'(n_r)) <= FIELD_SLOTS, "first-fit run leaves the pool")
  // a result is only loaded when the output register is free
  `ASSERT_NXT(a_no_overwrite, clk, rst_n, out_valid_r && !out_tready,
    out_valid_r && $stable(out_r), "pending result overwritten")
  // the bitmap is only written while clearing or marking
  `ASSERT_IMP(a_fd_write_state, clk, rst_n, fd_we,
    (state_r == S_CLR) || (state_r == S_MWR), "bitmap write outside mark pass")

endmodule

### design/rosa_ram.sv
module rosa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/refcounted_object_slot_allocator_unit_checker.sv
`timescale 1ns / 100ps

module refcounted_object_slot_allocator_unit_checker
  import rosa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  localparam int SLOTS  = OBJECT_SLOTS_DEF;
  localparam int FIELDS = FIELD_SLOTS_DEF;

  typedef struct packed {
    logic [15:0] count_after;
    logic [15:0] class_out;
    logic [8:0]  run_length;
    logic [7:0]  run_start;
    logic        freed;
    logic [5:0]  slot_index;
  } slot_result_t;

  typedef struct {
    status_t      status;
    slot_result_t data;
  } verdict_t;

  logic [15:0] use_count [SLOTS];
  logic [15:0] slot_class [SLOTS];
  logic [7:0]  run_base [SLOTS];
  logic [8:0]  run_len [SLOTS];
  logic        field_busy [FIELDS];

  verdict_t expected_results[$];

  // lowest free run of n slots, -1 if none
  function automatic int first_fit(int n);
    int run;
    run = 0;
    if (n == 0) return 0;
    if (n > FIELDS) return -1;
    for (int i = 0; i < FIELDS; i++) begin
      if (field_busy[i]) run = 0;
      else begin
        run++;
        if (run == n) return i + 1 - n;
      end
    end
    return -1;
  endfunction

  function automatic verdict_t apply_request(op_t op, logic [15:0] cls, logic [8:0] n,
                                             logic [5:0] idx);
    verdict_t v;
    int slot;
    int start;
    logic [15:0] cnt;
    v.status = ST_OK;
    v.data = '0;
    if (op == OP_ALLOC) begin
      slot = -1;
      for (int s = SLOTS - 1; s >= 0; s--)
        if (use_count[s] == 0) slot = s;
      if (slot < 0) begin
        v.status = ST_TABLE_FULL;
        return v;
      end
      start = first_fit(n);
      if (start < 0) begin
        v.status = ST_POOL_FULL;
        return v;
      end
      for (int k = 0; k < n; k++) field_busy[start + k] = 1'b1;
      slot_class[slot] = cls;
      run_base[slot] = start[7:0];
      run_len[slot] = n;
      use_count[slot] = 16'd1;
      v.data = '{16'd1, cls, n, start[7:0], 1'b0, slot[5:0]};
      return v;
    end
    cnt = use_count[idx];
    if (op == OP_RETAIN) begin
      if (cnt != 16'hFFFF) cnt++;
      use_count[idx] = cnt;
    end else if (op == OP_RELEASE) begin
      if (cnt == 0) begin
        v.status = ST_IGNORED;
        v.data = '{16'd0, slot_class[idx], 9'd0, 8'd0, 1'b0, idx};
        return v;
      end
      cnt--;
      use_count[idx] = cnt;
      if (cnt == 0) begin
        v.data = '{16'd0, slot_class[idx], run_len[idx], run_base[idx], 1'b1, idx};
        for (int k = 0; k < run_len[idx]; k++)
          if (run_base[idx] + k < FIELDS) field_busy[run_base[idx] + k] = 1'b0;
        slot_class[idx] = '0;
        run_base[idx] = '0;
        run_len[idx] = '0;
        return v;
      end
    end
    v.data = '{cnt, slot_class[idx], run_len[idx], run_base[idx], 1'b0, idx};
    return v;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (!rst_n) begin
      fail_count <= 0;
      expected_results.delete();
      for (int s = 0; s < SLOTS; s++) begin
        use_count[s] = '0;
        slot_class[s] = '0;
        run_base[s] = '0;
        run_len[s] = '0;
      end
      for (int f = 0; f < FIELDS; f++) field_busy[f] = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser);
        got.data = out_tdata;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat: %h/%h", out_tuser, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.status != got.status || want.data != got.data) begin
            if (fail_count < 10)
              $display("mismatch: exp st %0d slot %0d fr %0d rs %0d rl %0d cls %h cnt %0d | got st %0d slot %0d fr %0d rs %0d rl %0d cls %h cnt %0d",
                       want.status, want.data.slot_index, want.data.freed, want.data.run_start,
                       want.data.run_length, want.data.class_out, want.data.count_after,
                       got.status, got.data.slot_index, got.data.freed, got.data.run_start,
                       got.data.run_length, got.data.class_out, got.data.count_after);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_request(op_t'(in_tuser), in_tdata[15:0],
                                                 in_tdata[24:16], in_tdata[30:25]));
    end
  end

endmodule

### tb/refcounted_object_slot_allocator_unit_tb.sv
`timescale 1ns / 100ps

module refcounted_object_slot_allocator_unit_tb;
  import rosa_pkg::*;

  // Stall budget: an allocate may scan all 64 slots and 32 bitmap words, and the
  // clearing pass after reset walks 64 addresses.
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_REQUESTS = 1850;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          steady;     // true while no idling is injected

  refcounted_object_slot_allocator_unit uut (.*);

  refcounted_object_slot_allocator_unit_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure: ~8% stalls except during the steady stretch.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= steady || ($urandom_range(99) >= 8);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("refcounted_object_slot_allocator_unit_tb: done, errors");
      $finish;
    end
  end

  // One request beat; sender gaps come first so valid never drops between back-to-back beats.
  task automatic send_request(op_t op, logic [15:0] cls, logic [8:0] n, logic [5:0] idx);
    if (!steady && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, idx, n, cls};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Random request biased toward live slots and small runs so the bitmap fragments.
  task automatic random_request();
    int pick;
    logic [8:0] n;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) n = 9'($urandom_range(256));
    else if ($urandom_range(9) == 0) n = 9'($urandom_range(511));
    else n = 9'($urandom_range(12));
    if (pick < 40) send_request(OP_ALLOC, 16'($urandom), n, 6'($urandom));
    else if (pick < 55)
      send_request(OP_RETAIN, 16'($urandom), 9'($urandom), 6'($urandom_range(15)));
    else if (pick < 90)
      send_request(OP_RELEASE, 16'($urandom), 9'($urandom), 6'($urandom_range(31)));
    else
      send_request(op_t'($urandom_range(3)), 16'($urandom), 9'($urandom), 6'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_ALLOC;
    steady = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero length, full pool, oversize, retain/release corners, read op.
    send_request(OP_ALLOC, 16'hFFFF, 9'd0, 6'd0);
    send_request(OP_ALLOC, 16'h1234, 9'd256, 6'd63);
    send_request(OP_ALLOC, 16'h0001, 9'd1, 6'd0);
    send_request(OP_ALLOC, 16'h0002, 9'd511, 6'd0);
    send_request(OP_RELEASE, 16'h0, 9'd0, 6'd1);
    send_request(OP_ALLOC, 16'hA5A5, 9'd5, 6'd0);
    send_request(OP_RETAIN, 16'h0, 9'd0, 6'd1);
    send_request(OP_READ, 16'hFFFF, 9'h1FF, 6'd1);
    send_request(OP_RELEASE, 16'h0, 9'd0, 6'd1);
    send_request(OP_RELEASE, 16'h0, 9'd0, 6'd1);
    send_request(OP_RELEASE, 16'h0, 9'd0, 6'd1);
    send_request(OP_RETAIN, 16'h5555, 9'd0, 6'd63);
    send_request(OP_READ, 16'h0, 9'd0, 6'd63);
    send_request(OP_RELEASE, 16'h0, 9'd0, 6'd63);
    send_request(OP_RELEASE, 16'h0, 9'd0, 6'd0);
    send_request(OP_RELEASE, 16'h0, 9'd0, 6'd2);
    send_request(OP_ALLOC, 16'h7777, 9'd256, 6'd0);
    send_request(OP_RELEASE, 16'h0, 9'd0, 6'd0);
    // Fill the object table, then one allocate too many.
    for (int i = 0; i < 65; i++) send_request(OP_ALLOC, 16'($urandom), 9'd0, 6'd0);
    // A few extra references on slot 5, back to back.
    steady = 1'b1;
    for (int i = 0; i < 8; i++) send_request(OP_RETAIN, 16'h0, 9'd0, 6'd5);
    steady = 1'b0;
    for (int i = 0; i < 64; i++) send_request(OP_RELEASE, 16'h0, 9'd0, i[5:0]);
    send_request(OP_RELEASE, 16'h0, 9'd0, 6'd5);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      steady = (i >= 800 && i < 1100);
      random_request();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("refcounted_object_slot_allocator_unit_tb: done, clean");
    else $display("refcounted_object_slot_allocator_unit_tb: done, errors");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/rosa_pkg.sv
design/rosa_ram.sv
design/refcounted_object_slot_allocator_unit.sv
tb/refcounted_object_slot_allocator_unit_checker.sv
tb/refcounted_object_slot_allocator_unit_tb.sv
